/* src/joystick_average_normalizer_core_assert.svh */
// ----------------------------------------------------------------------------
// joystick average normalizer assertion macros
// concurrent checks clocked on clk and disabled during rst
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_AVERAGE_NORMALIZER_CORE_ASSERT_SVH
`define JOYSTICK_AVERAGE_NORMALIZER_CORE_ASSERT_SVH

// condition holds at every clock edge
`define JAN_ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// trigger at one edge implies condition at the next edge
`define JAN_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

/* src/jan_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jan_pkg
// shared constants, types and command/status bundles
// ----------------------------------------------------------------------------
package jan_pkg;

  localparam int WINDOW     = 128;
  localparam int WIN_BITS   = $clog2(WINDOW);
  localparam int SMP_W      = 12;
  localparam int SUM_W      = SMP_W + WIN_BITS;
  localparam int CNT_W      = WIN_BITS + 1;
  localparam int UPPER_W    = 14;
  localparam int SPAN_W     = 13;
  localparam int POS_W      = 7;
  localparam int NUM_W      = 19;
  localparam int STEP_W     = 3;
  localparam int FULL_SCALE = 100;
  localparam logic [SMP_W-1:0] LOW_OFFSET_RST = SMP_W'(100);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUSH,
    ST_CAL,
    ST_UPD,
    ST_AVG,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } jan_state_t;

  typedef struct packed {
    logic latch;
    logic push;
    logic cal;
    logic upd;
    logic avg;
    logic mul;
    logic div;
    logic load_out;
  } jan_cmd_t;

  typedef struct packed {
    logic fill_phase;
    logic fill_last;
    logic div_done;
    logic out_busy;
  } jan_sts_t;

endpackage

/* src/joystick_average_normalizer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_average_normalizer_core
// moving average of joystick adc samples with percent position output
// ----------------------------------------------------------------------------
// the first 128 items after reset fill the sample ring and give no result;
// the last one also latches the rest centre and sets the upper end of
// travel to 2*centre - low_offset. every later item swaps out the oldest
// ring entry and gives one result: the truncated window average and the
// position in percent, 0 below low_offset or for an empty span and
// saturating at 100. a steady-state item passes through the ring read and
// update, a constant scale by 100 and a restoring divider that makes one
// of the 7 quotient bits a cycle. the result sits in an output register,
// so a new item is taken while a result is still held by out_stall.
// low_offset resets to 100; low_offset is to be written only while idle,
// and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module joystick_average_normalizer_core (
  input  logic                      clk,
  input  logic                      rst,
  // config register
  input  logic                      low_offset_we,
  input  logic [jan_pkg::SMP_W-1:0] low_offset_wdata,
  // input channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [jan_pkg::SMP_W-1:0] sample,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [jan_pkg::SMP_W-1:0] average,
  output logic [jan_pkg::POS_W-1:0] position
);

  import jan_pkg::*;

  // command and status between sequencer and datapath
  jan_cmd_t cmd;
  jan_sts_t sts;

  // sequencer: decides fill vs steady path, steps the divider, waits on output
  jan_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: ring memory, running sum, calibration, divider, output register
  jan_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .sample           (sample),
    .low_offset_we    (low_offset_we),
    .low_offset_wdata (low_offset_wdata),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .average          (average),
    .position         (position),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule

/* src/jan_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jan_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module jan_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/jan_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jan_ctrl
// sequencer for fill, calibration, update and divide steps
// ----------------------------------------------------------------------------
module jan_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  jan_pkg::jan_sts_t sts,
  output jan_pkg::jan_cmd_t cmd
);

  import jan_pkg::*;

  jan_state_t state;
  jan_state_t state_next;
  logic       accept;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = sts.fill_phase ? ST_PUSH : ST_UPD;
        end
      end
      ST_PUSH: state_next = sts.fill_last ? ST_CAL : ST_IDLE;
      ST_CAL:  state_next = ST_IDLE;
      ST_UPD:  state_next = ST_AVG;
      ST_AVG:  state_next = ST_MUL;
      ST_MUL:  state_next = ST_DIV;
      ST_DIV: begin
        if (sts.div_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!sts.out_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: cmd.latch    = accept;
      ST_PUSH: cmd.push     = 1'b1;
      ST_CAL:  cmd.cal      = 1'b1;
      ST_UPD:  cmd.upd      = 1'b1;
      ST_AVG:  cmd.avg      = 1'b1;
      ST_MUL:  cmd.mul      = 1'b1;
      ST_DIV:  cmd.div      = 1'b1;
      ST_DONE: cmd.load_out = !sts.out_busy;
      default: cmd = '0;
    endcase
  end

`include "joystick_average_normalizer_core_assert.svh"

  `JAN_ASSERT_NOW(a_load_free, !(cmd.load_out && sts.out_busy), "result loaded over a held item")
  `JAN_ASSERT_NEXT(a_cal_after_fill, state == ST_PUSH && sts.fill_last, state == ST_CAL, "no calibration after last fill")
  `JAN_ASSERT_NEXT(a_div_exit, state == ST_DIV && sts.div_done, state == ST_DONE, "divider did not hand off")
  `JAN_ASSERT_NOW(a_upd_steady, !(state == ST_UPD && sts.fill_phase), "window update while still filling")

endmodule

/* src/jan_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jan_datapath
// sample ring, running sum, calibration, normalizer and output register
// ----------------------------------------------------------------------------
module jan_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [jan_pkg::SMP_W-1:0]        sample,
  input  logic                             low_offset_we,
  input  logic [jan_pkg::SMP_W-1:0]        low_offset_wdata,
  input  logic                             out_stall,
  output logic                             out_valid,
  output logic [jan_pkg::SMP_W-1:0]        average,
  output logic [jan_pkg::POS_W-1:0]        position,
  input  jan_pkg::jan_cmd_t                cmd,
  output jan_pkg::jan_sts_t                sts
);

  import jan_pkg::*;

  logic        [SMP_W-1:0]    smp;
  logic        [SMP_W-1:0]    low_off;
  logic        [SUM_W-1:0]    sum;
  logic        [WIN_BITS-1:0] widx;
  logic        [CNT_W-1:0]    fill_cnt;
  logic signed [UPPER_W-1:0]  upper_end;
  logic        [SMP_W-1:0]    avg_r;
  logic        [SMP_W-1:0]    diff_r;
  logic        [SPAN_W-1:0]   span_r;
  logic                       pos_zero;
  logic                       pos_full;
  logic        [NUM_W-1:0]    rem;
  logic        [POS_W-1:0]    quo;
  logic        [STEP_W-1:0]   step;
  logic        [SMP_W-1:0]    old_smp;

  logic        [SMP_W-1:0]    sum_avg;
  logic        [SUM_W-1:0]    sum_upd;
  logic signed [UPPER_W:0]    span_full;
  logic        [SMP_W-1:0]    diff;
  logic        [NUM_W:0]      trial;
  logic                       ram_we;

  assign sum_avg   = sum[SUM_W-1:WIN_BITS];
  // window sum with the oldest entry swapped for the new sample
  assign sum_upd   = sum - SUM_W'(old_smp) + SUM_W'(smp);
  assign span_full = $signed({upper_end[UPPER_W-1], upper_end})
                   - $signed({{(UPPER_W+1-SMP_W){1'b0}}, low_off});
  assign diff      = avg_r - low_off;
  assign trial     = (NUM_W+1)'({{(NUM_W+1-SPAN_W){1'b0}}, span_r} << step);
  assign ram_we    = cmd.push || cmd.upd;

  jan_ram #(
    .WIDTH (SMP_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (widx),
    .wdata (smp),
    .raddr (widx),
    .rdata (old_smp)
  );

  assign sts.fill_phase = (fill_cnt < CNT_W'(WINDOW));
  assign sts.fill_last  = (fill_cnt == CNT_W'(WINDOW - 1));
  assign sts.div_done   = (step == '0);
  assign sts.out_busy   = out_valid && out_stall;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      low_off <= LOW_OFFSET_RST;
    end else if (low_offset_we) begin
      low_off <= low_offset_wdata;
    end
  end

  // window state
  always_ff @(posedge clk) begin
    if (rst) begin
      sum       <= '0;
      widx      <= '0;
      fill_cnt  <= '0;
      upper_end <= '0;
    end else begin
      if (cmd.push) begin
        sum      <= sum + SUM_W'(smp);
        widx     <= widx + 1'b1;
        fill_cnt <= fill_cnt + 1'b1;
      end
      if (cmd.upd) begin
        sum  <= sum_upd;
        widx <= widx + 1'b1;
      end
      if (cmd.cal) begin
        upper_end <= $signed({1'b0, sum_avg, 1'b0}) - $signed({2'b00, low_off});
      end
    end
  end

  // normalizer: compare, scale, restoring divide one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      smp <= sample;
    end
    if (cmd.upd) begin
      avg_r <= sum_upd[SUM_W-1:WIN_BITS];
    end
    if (cmd.avg) begin
      pos_zero <= (avg_r < low_off) || (span_full <= 0);
      pos_full <= $signed({{(UPPER_W+1-SMP_W){1'b0}}, diff}) >= span_full;
      diff_r   <= diff;
      span_r   <= span_full[SPAN_W-1:0];
    end
    if (cmd.mul) begin
      rem  <= NUM_W'({{(NUM_W-SMP_W){1'b0}}, diff_r} * NUM_W'(FULL_SCALE));
      quo  <= '0;
      step <= STEP_W'(POS_W - 1);
    end
    if (cmd.div) begin
      if ({1'b0, rem} >= trial) begin
        rem       <= rem - trial[NUM_W-1:0];
        quo[step] <= 1'b1;
      end
      step <= step - 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      average <= avg_r;
      if (pos_zero) begin
        position <= '0;
      end else if (pos_full) begin
        position <= POS_W'(FULL_SCALE);
      end else begin
        position <= quo;
      end
    end
  end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the joystick moving average and percent normalizer
// ----------------------------------------------------------------------------
// a clocked driver takes samples and low_offset writes from a plan queue,
// with random gaps between items. a clocked monitor applies random
// back-pressure and compares every result with the oldest prediction. the
// prediction comes from a local model of the ring, the running sum, the
// calibrated upper end and the current low_offset.
// ----------------------------------------------------------------------------
module tb_top;
  import jan_pkg::*;

  // cycles the block gets to finish a result-less item before a register write
  localparam int SETTLE_CYCLES = 24;
  localparam int SMP_MAX       = (1 << SMP_W) - 1;

  typedef enum logic [1:0] {
    ACT_SAMPLE,   // one input item
    ACT_CFG,      // write low_offset with a fixed value
    ACT_CFG_REL,  // write low_offset as upper end minus a distance
    ACT_HOLD      // wait for every pending result, no write
  } act_kind_t;

  typedef struct {
    act_kind_t   kind;
    int unsigned val;
  } act_t;

  typedef struct packed {
    logic [SMP_W-1:0] average;
    logic [POS_W-1:0] position;
  } joy_result_t;

  // clock, reset and block ports; the driven ones are known from time zero
  logic             clk              = 1'b0;
  logic             rst              = 1'b1;
  logic             low_offset_we    = 1'b0;
  logic [SMP_W-1:0] low_offset_wdata = '0;
  logic             in_valid         = 1'b0;
  logic             in_stall;
  logic [SMP_W-1:0] sample           = '0;
  logic             out_valid;
  logic             out_stall        = 1'b0;
  logic [SMP_W-1:0] average;
  logic [POS_W-1:0] position;

  // pending stimulus and predicted results
  act_t        plan_q[$];
  joy_result_t result_q[$];
  bit          failed = 1'b0;

  // local copy of the filter state
  logic [SMP_W-1:0]        ring_m[WINDOW];
  logic [SUM_W-1:0]        sum_m;
  logic [WIN_BITS-1:0]     widx_m;
  int                      fill_m;
  logic signed [UPPER_W-1:0] upper_m;
  logic [SMP_W-1:0]        low_m;

  // idle pattern state for both sides
  int unsigned send_calm_left = 0;
  bit          send_calm      = 1'b0;
  int unsigned recv_calm_left = 0;
  bit          recv_calm      = 1'b0;
  int unsigned gap_left       = 0;
  int unsigned settle_cnt     = 0;
  int unsigned stall_left     = 0;

  joystick_average_normalizer_core u_top (
    .clk              (clk),
    .rst              (rst),
    .low_offset_we    (low_offset_we),
    .low_offset_wdata (low_offset_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .sample           (sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .average          (average),
    .position         (position)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #8_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // percent position of a window average against the calibrated travel
  function automatic logic [POS_W-1:0] percent_of(input logic [SMP_W-1:0] avg);
    int span;
    int diff;
    span = int'(upper_m) - int'(low_m);
    // below the zero end, or no usable span
    if (avg < low_m || span <= 0) return '0;
    diff = int'(avg) - int'(low_m);
    // beyond the upper end saturates
    if (diff >= span) return POS_W'(FULL_SCALE);
    return POS_W'((diff * FULL_SCALE) / span);
  endfunction

  // advance the model by one accepted sample
  task automatic predict_filter(input logic [SMP_W-1:0] s);
    logic [SMP_W-1:0] avg;
    joy_result_t      res;
    if (fill_m < WINDOW) begin
      // fill phase: no result, the last fill item calibrates
      sum_m        = sum_m + SUM_W'(s);
      ring_m[widx_m] = s;
      widx_m       = widx_m + 1'b1;
      fill_m++;
      if (fill_m == WINDOW) begin
        avg     = SMP_W'(sum_m / WINDOW);
        upper_m = UPPER_W'(2 * int'(avg) - int'(low_m));
      end
    end else begin
      // steady state: swap out the oldest entry
      sum_m          = sum_m - SUM_W'(ring_m[widx_m]) + SUM_W'(s);
      ring_m[widx_m] = s;
      widx_m         = widx_m + 1'b1;
      avg            = SMP_W'(sum_m / WINDOW);
      res.average    = avg;
      res.position   = percent_of(avg);
      result_q.push_back(res);
    end
  endtask

  // cycles to idle before the next item or result, with calm stretches
  function automatic int unsigned draw_idle(inout int unsigned calm_left, inout bit calm);
    if (calm_left == 0) begin
      calm      = ($urandom_range(0, 2) == 0);
      calm_left = $urandom_range(8, 64);
    end
    calm_left--;
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  // ---------------------------------------------------------------------------
  // driver: one item or one register write at a time from plan_q
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    logic             nxt_valid;
    logic             nxt_we;
    logic [SMP_W-1:0] nxt_sample;
    logic [SMP_W-1:0] nxt_wdata;
    int               rel;
    if (rst) begin
      in_valid         <= 1'b0;
      sample           <= '0;
      low_offset_we    <= 1'b0;
      low_offset_wdata <= '0;
      gap_left   = 0;
      settle_cnt = 0;
    end else begin
      nxt_valid  = in_valid;
      nxt_sample = sample;
      nxt_we     = 1'b0;
      nxt_wdata  = low_offset_wdata;
      // item taken at this edge
      if (in_valid && !in_stall) begin
        predict_filter(sample);
        nxt_valid = 1'b0;
        gap_left  = draw_idle(send_calm_left, send_calm);
      end
      if (!nxt_valid) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (plan_q.size() != 0) begin
          if (plan_q[0].kind == ACT_SAMPLE) begin
            nxt_valid  = 1'b1;
            nxt_sample = plan_q[0].val[SMP_W-1:0];
            settle_cnt = 0;
            void'(plan_q.pop_front());
          end else if (result_q.size() == 0 && !out_valid) begin
            // idle: let a possible result-less item finish first
            if (settle_cnt < SETTLE_CYCLES) begin
              settle_cnt++;
            end else begin
              settle_cnt = 0;
              if (plan_q[0].kind != ACT_HOLD) begin
                if (plan_q[0].kind == ACT_CFG_REL) begin
                  rel = int'(upper_m) - int'(plan_q[0].val);
                  if (rel < 0) rel = 0;
                  if (rel > SMP_MAX) rel = SMP_MAX;
                  nxt_wdata = SMP_W'(rel);
                end else begin
                  nxt_wdata = plan_q[0].val[SMP_W-1:0];
                end
                nxt_we = 1'b1;
                low_m  = nxt_wdata;
              end
              void'(plan_q.pop_front());
            end
          end else begin
            settle_cnt = 0;
          end
        end
      end
      in_valid         <= nxt_valid;
      sample           <= nxt_sample;
      low_offset_we    <= nxt_we;
      low_offset_wdata <= nxt_wdata;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: random back-pressure and in-order compare
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    joy_result_t exp_res;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          $error("result with nothing pending: average %0d position %0d", average, position);
          failed = 1'b1;
        end else begin
          exp_res = result_q.pop_front();
          if (average !== exp_res.average) begin
            $error("average: expected %0d actual %0d", exp_res.average, average);
            failed = 1'b1;
          end
          if (position !== exp_res.position) begin
            $error("position: expected %0d actual %0d", exp_res.position, position);
            failed = 1'b1;
          end
        end
        stall_left = draw_idle(recv_calm_left, recv_calm);
      end else if (out_valid && stall_left != 0) begin
        // stall only counts down while a result is held
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus plan
  // ---------------------------------------------------------------------------
  task automatic push_act(input act_kind_t kind, input int unsigned val);
    act_t a;
    a.kind = kind;
    a.val  = val;
    plan_q.push_back(a);
  endtask

  // runs of level-plus-noise, uniform, rail-to-rail and ramp samples
  task automatic add_random_samples(input int n);
    int left;
    int mode;
    int run;
    int level;
    int noise;
    int step;
    int v;
    left = n;
    while (left > 0) begin
      mode  = $urandom_range(0, 3);
      run   = $urandom_range(16, 200);
      if (run > left) run = left;
      level = $urandom_range(0, SMP_MAX);
      noise = $urandom_range(0, 300);
      step  = int'($urandom_range(0, 64)) - 32;
      for (int i = 0; i < run; i++) begin
        case (mode)
          0: v = level + int'($urandom_range(0, 2 * noise)) - noise;
          1: v = $urandom_range(0, SMP_MAX);
          2: v = $urandom_range(0, 1) ? SMP_MAX : 0;
          default: v = level + i * step;
        endcase
        if (v < 0) v = 0;
        if (v > SMP_MAX) v = SMP_MAX;
        push_act(ACT_SAMPLE, v);
      end
      left -= run;
    end
  endtask

  initial begin
    // model reset
    for (int i = 0; i < WINDOW; i++) ring_m[i] = '0;
    sum_m   = '0;
    widx_m  = '0;
    fill_m  = 0;
    upper_m = '0;
    low_m   = LOW_OFFSET_RST;

    // fill phase under a non-default zero end; centre lands near 2050
    push_act(ACT_CFG, 1000);
    push_act(ACT_SAMPLE, 0);
    push_act(ACT_SAMPLE, SMP_MAX);
    push_act(ACT_SAMPLE, 12'hAAA);
    push_act(ACT_SAMPLE, 12'h555);
    for (int i = 4; i < WINDOW; i++) push_act(ACT_SAMPLE, $urandom_range(1800, 2300));

    // directed: full travel with zero end at 0
    push_act(ACT_CFG, 0);
    push_act(ACT_SAMPLE, SMP_MAX);
    push_act(ACT_SAMPLE, 0);
    push_act(ACT_SAMPLE, SMP_MAX);
    push_act(ACT_SAMPLE, 12'hAAA);
    push_act(ACT_SAMPLE, 12'h555);
    // zero end above the upper end: negative span, average below zero end
    push_act(ACT_CFG, SMP_MAX);
    push_act(ACT_SAMPLE, SMP_MAX);
    push_act(ACT_SAMPLE, SMP_MAX);
    push_act(ACT_SAMPLE, 0);
    // span of one count, then an empty span
    push_act(ACT_CFG_REL, 1);
    push_act(ACT_SAMPLE, SMP_MAX);
    push_act(ACT_SAMPLE, SMP_MAX);
    push_act(ACT_SAMPLE, 0);
    push_act(ACT_CFG_REL, 0);
    push_act(ACT_SAMPLE, SMP_MAX);
    push_act(ACT_SAMPLE, 0);
    // back to the reset value
    push_act(ACT_CFG, 100);
    push_act(ACT_SAMPLE, 0);
    push_act(ACT_SAMPLE, SMP_MAX);
    push_act(ACT_HOLD, 0);

    // random phases, each under a new zero end or a hold without a write
    for (int p = 0; p < 8; p++) begin
      case ($urandom_range(0, 5))
        0: push_act(ACT_CFG, 0);
        1: push_act(ACT_CFG, SMP_MAX);
        2: push_act(ACT_CFG, $urandom_range(0, SMP_MAX));
        3: push_act(ACT_CFG_REL, $urandom_range(0, 400));
        4: push_act(ACT_CFG, $urandom_range(500, 1500));
        default: push_act(ACT_HOLD, 0);
      endcase
      add_random_samples(145);
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // sampled at the falling edge so every clocked update has settled
    do @(negedge clk);
    while (plan_q.size() != 0 || in_valid || result_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (result_q.size() != 0) begin
      $error("%0d results never arrived", result_q.size());
      failed = 1'b1;
    end
    if (!failed) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/jan_pkg.sv
src/jan_ram.sv
src/jan_ctrl.sv
src/jan_datapath.sv
src/joystick_average_normalizer_core.sv
test/tb_top.sv
